// ----- rtl/core/address_lease_pool_allocator_defines.svh -----
// assertion macros for the lease pool allocator
`ifndef ADDRESS_LEASE_POOL_ALLOCATOR_DEFINES_SVH
`define ADDRESS_LEASE_POOL_ALLOCATOR_DEFINES_SVH

`ifndef SYNTH
`define ALPA_ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("alpa assertion failed");
`define ALPA_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("alpa assertion failed");
`else
`define ALPA_ASSERT_IMPLY(label, clk, rst_n, a, b)
`define ALPA_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif

`endif

// ----- rtl/core/alpa_pkg.sv -----
package alpa_pkg;

    localparam int POOL_SLOTS = 64;
    localparam int IDX_W      = $clog2(POOL_SLOTS);
    localparam int CNT_W      = $clog2(POOL_SLOTS + 1);
    localparam int MAC_W      = 48;
    localparam int IP_W       = 32;
    localparam int TIME_W     = 32;
    localparam int ENTRY_W    = MAC_W + TIME_W;

    localparam logic [IP_W-1:0]   POOL_FIRST_RST = 32'hC0A8_010A;
    localparam logic [IP_W-1:0]   POOL_LAST_RST  = 32'hC0A8_0149;
    localparam logic [TIME_W-1:0] LEASE_RST      = TIME_W'(24 * 60 * 60);

    typedef enum logic [1:0] {
        OP_ALLOCATE = 2'd0,
        OP_CHECK    = 2'd1,
        OP_LOAD     = 2'd2,
        OP_UNUSED   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CFG_POOL_FIRST  = 2'd0,
        CFG_POOL_LAST   = 2'd1,
        CFG_LEASE_TICKS = 2'd2,
        CFG_NONE        = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_NEW         = 4'd0,
        ST_RENEWED     = 4'd1,
        ST_EXHAUSTED   = 4'd2,
        ST_ACK         = 4'd3,
        ST_NAK         = 4'd4,
        ST_DROPPED     = 4'd5,
        ST_LOADED      = 4'd6,
        ST_OUT_OF_POOL = 4'd7,
        ST_DUP_MAC     = 4'd8,
        ST_DUP_IP      = 4'd9
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_DONE
    } fsm_t;

endpackage

// ----- rtl/core/alpa_ram.sv -----
module alpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/address_lease_pool_allocator.sv -----
// channel   dir  signals                           contents
// s_        in   tvalid tready tdata[111:0] tuser  request item: op, address, mac, time
// m_        out  tvalid tready tdata[31:0] tuser   result item: address, status
// cfg_      in   valid ready index[1:0] data       register writes, always ready
//
// allocate and load walk the clipped pool one slot a cycle through the lease ram,
// an acked check walks all slots to prune expired leases; the lease ram has a single
// read port; after the walk come the write and done states, then the output register
// nak, drop, unused op and out-of-pool load go from idle straight to done, no walk
// valid bits sit in flops and clear at once on reset; mac and expiry are not cleared
// one item at a time; a stalled result holds in the output register
`include "address_lease_pool_allocator_defines.svh"

module address_lease_pool_allocator
    import alpa_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [111:0]      s_tdata,   // requested_ip, client_mac, now
    input  logic [1:0]        s_tuser,   // op
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [IP_W-1:0]   m_tdata,   // ip_result
    output logic [3:0]        m_tuser,   // status
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [31:0]       cfg_data
);

    logic [IP_W-1:0]   first_reg, last_reg;
    logic [TIME_W-1:0] lease_reg;

    fsm_t state_reg, state_next;
    logic [POOL_SLOTS-1:0] valid_reg, valid_next;

    op_t               op_reg, op_next;
    logic [IP_W-1:0]   req_reg, req_next;
    logic [MAC_W-1:0]  mac_reg, mac_next;
    logic [TIME_W-1:0] now_reg, now_next;
    logic [TIME_W-1:0] exp_reg, exp_next;
    logic [CNT_W-1:0]  end_reg, end_next;
    logic [IDX_W-1:0]  ridx_reg, ridx_next;
    logic              have_req_reg, have_req_next;

    logic [CNT_W-1:0]  rd_cnt_reg, rd_cnt_next;
    logic              pend_reg, pend_next;
    logic [IDX_W-1:0]  pidx_reg, pidx_next;

    logic              have_ex_reg, have_ex_next;
    logic [IDX_W-1:0]  ex_reg, ex_next;
    logic              have_vir_reg, have_vir_next;
    logic [IDX_W-1:0]  vir_reg, vir_next;
    logic              have_rec_reg, have_rec_next;
    logic [IDX_W-1:0]  rec_reg, rec_next;
    logic              dup_reg, dup_next;

    logic [IP_W-1:0]   res_ip_reg, res_ip_next;
    status_t           res_st_reg, res_st_next;
    logic              m_valid_reg, m_valid_next;
    logic [IP_W-1:0]   m_data_reg, m_data_next;
    status_t           m_user_reg, m_user_next;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

    // accept-time decode
    logic [IP_W-1:0]   in_req, span, off;
    logic [MAC_W-1:0]  in_mac;
    logic [TIME_W-1:0] in_now;
    logic [CNT_W-1:0]  n_slots;
    logic              in_pool;
    logic [TIME_W:0]   exp_sum;
    logic              accept, out_free;

    // scan data
    logic [MAC_W-1:0]  d_mac;
    logic [TIME_W-1:0] d_exp;
    logic              d_valid, d_match, d_other, d_live, d_usable;
    logic [IDX_W-1:0]  tgt;

    assign in_req     = s_tdata[31:0];
    assign in_mac     = s_tdata[79:32];
    assign in_now     = s_tdata[111:80];
    assign accept     = s_tvalid && s_tready;
    assign out_free   = !m_valid_reg || m_tready;

    assign span = last_reg - first_reg;
    always_comb begin
        if (last_reg < first_reg) begin
            n_slots = '0;
        end else if (span >= IP_W'(POOL_SLOTS - 1)) begin
            n_slots = CNT_W'(POOL_SLOTS);
        end else begin
            n_slots = span[CNT_W-1:0] + CNT_W'(1);
        end
    end
    assign off     = in_req - first_reg;
    assign in_pool = (in_req != '0) && (in_req >= first_reg) && (off < IP_W'(n_slots));
    assign exp_sum = {1'b0, in_now} + {1'b0, lease_reg};

    assign d_mac    = ram_rdata[MAC_W-1:0];
    assign d_exp    = ram_rdata[ENTRY_W-1:MAC_W];
    assign d_valid  = valid_reg[pidx_reg];
    assign d_match  = d_valid && (d_mac == mac_reg);
    assign d_other  = d_valid && !d_match;
    assign d_live   = d_other && (now_reg < d_exp);
    assign d_usable = (first_reg + IP_W'(pidx_reg)) != '0;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg <= POOL_FIRST_RST;
            last_reg  <= POOL_LAST_RST;
            lease_reg <= LEASE_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_POOL_FIRST:  first_reg <= cfg_data;
                CFG_POOL_LAST:   last_reg  <= cfg_data;
                CFG_LEASE_TICKS: lease_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    priority if (op_t'(s_tuser) == OP_ALLOCATE) begin
                        state_next = S_SCAN;
                    end else if (op_t'(s_tuser) == OP_CHECK) begin
                        state_next = (in_req != '0 && in_pool && valid_reg[off[IDX_W-1:0]])
                                     ? S_SCAN : S_DONE;
                    end else if (op_t'(s_tuser) == OP_LOAD) begin
                        state_next = in_pool ? S_SCAN : S_DONE;
                    end else begin
                        state_next = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                if (!pend_reg && rd_cnt_reg >= end_reg) begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE: state_next = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        s_tready      = (state_reg == S_IDLE);
        valid_next    = valid_reg;
        op_next       = op_reg;
        req_next      = req_reg;
        mac_next      = mac_reg;
        now_next      = now_reg;
        exp_next      = exp_reg;
        end_next      = end_reg;
        ridx_next     = ridx_reg;
        have_req_next = have_req_reg;
        rd_cnt_next   = rd_cnt_reg;
        pend_next     = 1'b0;
        pidx_next     = pidx_reg;
        have_ex_next  = have_ex_reg;
        ex_next       = ex_reg;
        have_vir_next = have_vir_reg;
        vir_next      = vir_reg;
        have_rec_next = have_rec_reg;
        rec_next      = rec_reg;
        dup_next      = dup_reg;
        res_ip_next   = res_ip_reg;
        res_st_next   = res_st_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;
        m_user_next   = m_user_reg;
        ram_we        = 1'b0;
        ram_waddr     = ridx_reg;
        ram_wdata     = {exp_reg, mac_reg};
        tgt           = ridx_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    op_next       = op_t'(s_tuser);
                    req_next      = in_req;
                    mac_next      = in_mac;
                    now_next      = in_now;
                    exp_next      = exp_sum[TIME_W] ? '1 : exp_sum[TIME_W-1:0];
                    ridx_next     = off[IDX_W-1:0];
                    have_req_next = in_pool;
                    end_next      = (op_t'(s_tuser) == OP_CHECK) ? CNT_W'(POOL_SLOTS)
                                                                   : n_slots;
                    rd_cnt_next   = '0;
                    have_ex_next  = 1'b0;
                    have_vir_next = 1'b0;
                    have_rec_next = 1'b0;
                    dup_next      = 1'b0;
                    res_ip_next   = '0;
                    priority if (op_t'(s_tuser) == OP_ALLOCATE) begin
                        res_st_next = ST_EXHAUSTED;
                    end else if (op_t'(s_tuser) == OP_CHECK) begin
                        priority if (in_req == '0) begin
                            res_st_next = ST_DROPPED;
                        end else if (!in_pool || !valid_reg[off[IDX_W-1:0]]) begin
                            res_st_next = ST_NAK;
                        end else begin
                            res_st_next = ST_ACK;
                            res_ip_next = in_req;
                        end
                    end else if (op_t'(s_tuser) == OP_LOAD) begin
                        res_st_next = ST_OUT_OF_POOL;
                    end else begin
                        res_st_next = ST_DROPPED;
                    end
                end
            end
            S_SCAN: begin
                if (rd_cnt_reg < end_reg) begin
                    pend_next   = 1'b1;
                    pidx_next   = rd_cnt_reg[IDX_W-1:0];
                    rd_cnt_next = rd_cnt_reg + CNT_W'(1);
                end
                if (pend_reg) begin
                    unique case (op_reg)
                        OP_ALLOCATE: begin
                            if (d_match && !have_ex_reg) begin
                                have_ex_next = 1'b1;
                                ex_next      = pidx_reg;
                            end
                            if (d_other && pidx_reg == ridx_reg) begin
                                have_req_next = 1'b0;
                            end
                            if (d_usable && !d_other && !have_vir_reg) begin
                                have_vir_next = 1'b1;
                                vir_next      = pidx_reg;
                            end
                            if (d_usable && !d_live && !have_rec_reg) begin
                                have_rec_next = 1'b1;
                                rec_next      = pidx_reg;
                            end
                        end
                        OP_CHECK: begin
                            // prune expired leases, whole table
                            if (d_valid && now_reg >= d_exp) begin
                                valid_next[pidx_reg] = 1'b0;
                            end
                        end
                        OP_LOAD: begin
                            if (d_match) begin
                                dup_next = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_WRITE: begin
                unique case (op_reg)
                    OP_ALLOCATE: begin
                        priority if (have_ex_reg) begin
                            tgt = ex_reg;
                            if (have_req_reg && ridx_reg != ex_reg) begin
                                valid_next[ex_reg] = 1'b0;
                                tgt = ridx_reg;
                            end
                            res_st_next = ST_RENEWED;
                        end else if (have_req_reg) begin
                            tgt         = ridx_reg;
                            res_st_next = ST_NEW;
                        end else if (have_vir_reg) begin
                            tgt         = vir_reg;
                            res_st_next = ST_NEW;
                        end else if (have_rec_reg) begin
                            tgt         = rec_reg;
                            res_st_next = ST_NEW;
                        end else begin
                            res_st_next = ST_EXHAUSTED;
                        end
                        if (res_st_next != ST_EXHAUSTED) begin
                            ram_we          = 1'b1;
                            ram_waddr       = tgt;
                            valid_next[tgt] = 1'b1;
                            res_ip_next     = first_reg + IP_W'(tgt);
                        end
                    end
                    OP_LOAD: begin
                        priority if (dup_reg) begin
                            res_st_next = ST_DUP_MAC;
                        end else if (valid_reg[ridx_reg]) begin
                            res_st_next = ST_DUP_IP;
                        end else begin
                            ram_we               = 1'b1;
                            valid_next[ridx_reg] = 1'b1;
                            res_st_next          = ST_LOADED;
                            res_ip_next          = req_reg;
                        end
                    end
                    default: ;
                endcase
            end
            S_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_ip_reg;
                    m_user_next  = res_st_reg;
                end
            end
            default: ;
        endcase
    end

    alpa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (POOL_SLOTS)
    ) u_lease_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_cnt_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
            pend_reg    <= 1'b0;
            rd_cnt_reg  <= '0;
        end else begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            m_valid_reg <= m_valid_next;
            pend_reg    <= pend_next;
            rd_cnt_reg  <= rd_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        req_reg      <= req_next;
        mac_reg      <= mac_next;
        now_reg      <= now_next;
        exp_reg      <= exp_next;
        end_reg      <= end_next;
        ridx_reg     <= ridx_next;
        have_req_reg <= have_req_next;
        pidx_reg     <= pidx_next;
        have_ex_reg  <= have_ex_next;
        ex_reg       <= ex_next;
        have_vir_reg <= have_vir_next;
        vir_reg      <= vir_next;
        have_rec_reg <= have_rec_next;
        rec_reg      <= rec_next;
        dup_reg      <= dup_next;
        res_ip_reg   <= res_ip_next;
        res_st_reg   <= res_st_next;
        m_data_reg   <= m_data_next;
        m_user_reg   <= m_user_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    `ALPA_ASSERT_NEXT(a_one_item, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    `ALPA_ASSERT_IMPLY(a_write_at_end, aclk, aresetn, ram_we, state_reg == S_WRITE)
    `ALPA_ASSERT_IMPLY(a_fail_zero_ip, aclk, aresetn,
        m_tvalid && m_tuser != ST_NEW && m_tuser != ST_RENEWED && m_tuser != ST_ACK
        && m_tuser != ST_LOADED, m_tdata == '0)

endmodule
